### sv/mrpc_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and status codes for the MRP composition pipeline.
// No dependencies.
package mrpc_pkg;

   localparam int FRAC_BITS = 14;
   localparam int DW        = 16;               // input and output component width
   localparam int SQ_W      = 2 * DW;           // one 16x16 product
   localparam int MAG_W     = 2 * DW;           // sum of three squares
   localparam int DOT_W     = 2 * DW + 1;       // signed sum of products
   localparam int C_W       = MAG_W - FRAC_BITS + 1;   // 1 - |v|^2, signed
   localparam int PROD_W    = 2 * MAG_W;        // |a|^2 * |b|^2
   localparam int DEN_W     = 40;               // signed denominator
   localparam int CP_W      = C_W + DW;         // (1 - |v|^2) * component
   localparam int NUM_W     = 37;               // signed numerator
   localparam int NMAG_W    = NUM_W - 1;
   localparam int DMAG_W    = DEN_W;
   localparam int QW        = DW;               // quotient bits resolved by the divider
   localparam int REM_W     = NMAG_W + FRAC_BITS;
   localparam int CMP_W     = DMAG_W + QW + 1;

   localparam logic [C_W-1:0]   ONE_F  = C_W'(1) << FRAC_BITS;
   localparam logic [DEN_W-1:0] ONE_2F = DEN_W'(1) << (2 * FRAC_BITS);

   localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
   localparam logic [QW-1:0] NEG_MAX = {1'b1, {(QW-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_ZERO = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0][DW-1:0] a;
      logic [2:0][DW-1:0] b;
   } vec_pair_type;

   typedef struct packed {
      logic [2:0][NMAG_W-1:0] nmag;
      logic [2:0]             neg;
      logic [DMAG_W-1:0]      dmag;
      logic                   zero;
   } div_in_type;

   typedef struct packed {
      logic [2:0][REM_W-1:0] rem;
      logic [2:0][QW-1:0]    q;
      logic [2:0]            ovf;
      logic [2:0]            neg;
      logic [DMAG_W-1:0]     dmag;
      logic                  zero;
   } div_stage_type;

   typedef struct packed {
      logic [2:0][QW-1:0] q;
      logic [2:0]         ovf;
      logic [2:0]         neg;
      logic               zero;
   } div_out_type;

endpackage

### sv/mrpc_front.sv
`timescale 1ns / 1ps
// Five-stage front end: products, norms, dot and cross products, numerator and denominator.
// Depends on mrpc_pkg.
module mrpc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mrpc_pkg::vec_pair_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mrpc_pkg::div_in_type out_data
);
   import mrpc_pkg::*;

   logic [4:0] v_ff;
   logic [5:0] adv;

   // stage 1
   logic        [SQ_W-1:0] sqa_ff [3];
   logic        [SQ_W-1:0] sqb_ff [3];
   logic signed [SQ_W-1:0] pd_ff  [3];
   logic signed [SQ_W-1:0] xpp_ff [3];
   logic signed [SQ_W-1:0] xpn_ff [3];
   vec_pair_type           v1_ff;
   // stage 2
   logic        [MAG_W-1:0] maga_ff, magb_ff;
   logic signed [DOT_W-1:0] dot2_ff;
   logic signed [DOT_W-1:0] cr2_ff [3];
   vec_pair_type            v2_ff;
   // stage 3
   logic signed [C_W-1:0]   ca_ff, cb_ff;
   logic        [PROD_W-1:0] prod_ff;
   logic signed [DOT_W-1:0] dot3_ff;
   logic signed [DOT_W-1:0] cr3_ff [3];
   vec_pair_type            v3_ff;
   // stage 4
   logic signed [DEN_W-1:0] den_ff;
   logic signed [CP_W-1:0]  pa_ff [3];
   logic signed [CP_W-1:0]  pb_ff [3];
   logic signed [DOT_W-1:0] cr4_ff [3];
   // stage 5
   div_in_type              out_ff, out_in;

   always_comb begin
      adv[5] = out_ready;
      for (int k = 4; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end
   assign in_ready  = adv[0];
   assign out_valid = v_ff[4];
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < 5; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int i = 0; i < 3; i++) begin
            sqa_ff[i] <= $signed(in_data.a[i]) * $signed(in_data.a[i]);
            sqb_ff[i] <= $signed(in_data.b[i]) * $signed(in_data.b[i]);
            pd_ff[i]  <= $signed(in_data.a[i]) * $signed(in_data.b[i]);
         end
         // cross product b x a, positive and negative terms
         xpp_ff[0] <= $signed(in_data.b[1]) * $signed(in_data.a[2]);
         xpn_ff[0] <= $signed(in_data.b[2]) * $signed(in_data.a[1]);
         xpp_ff[1] <= $signed(in_data.b[2]) * $signed(in_data.a[0]);
         xpn_ff[1] <= $signed(in_data.b[0]) * $signed(in_data.a[2]);
         xpp_ff[2] <= $signed(in_data.b[0]) * $signed(in_data.a[1]);
         xpn_ff[2] <= $signed(in_data.b[1]) * $signed(in_data.a[0]);
         v1_ff <= in_data;
      end
      if (adv[1]) begin
         maga_ff <= sqa_ff[0] + sqa_ff[1] + sqa_ff[2];
         magb_ff <= sqb_ff[0] + sqb_ff[1] + sqb_ff[2];
         dot2_ff <= DOT_W'(pd_ff[0]) + DOT_W'(pd_ff[1]) + DOT_W'(pd_ff[2]);
         for (int i = 0; i < 3; i++) begin
            cr2_ff[i] <= DOT_W'(xpp_ff[i]) - DOT_W'(xpn_ff[i]);
         end
         v2_ff <= v1_ff;
      end
      if (adv[2]) begin
         ca_ff   <= ONE_F - C_W'(maga_ff >> FRAC_BITS);
         cb_ff   <= ONE_F - C_W'(magb_ff >> FRAC_BITS);
         prod_ff <= maga_ff * magb_ff;
         dot3_ff <= dot2_ff;
         cr3_ff  <= cr2_ff;
         v3_ff   <= v2_ff;
      end
      if (adv[3]) begin
         den_ff <= ONE_2F + DEN_W'(prod_ff >> (2 * FRAC_BITS)) - (DEN_W'(dot3_ff) <<< 1);
         for (int i = 0; i < 3; i++) begin
            pa_ff[i] <= ca_ff * $signed(v3_ff.b[i]);
            pb_ff[i] <= cb_ff * $signed(v3_ff.a[i]);
         end
         cr4_ff <= cr3_ff;
      end
      if (adv[4]) begin
         out_ff <= out_in;
      end
   end

   always_comb begin
      logic signed [NUM_W-1:0] num;
      out_in = '0;
      for (int i = 0; i < 3; i++) begin
         num = NUM_W'(pa_ff[i]) + NUM_W'(pb_ff[i]) - (NUM_W'(cr4_ff[i]) <<< 1);
         out_in.nmag[i] = num[NUM_W-1] ? NMAG_W'(-num) : NMAG_W'(num);
         out_in.neg[i]  = num[NUM_W-1] ^ den_ff[DEN_W-1];
      end
      out_in.dmag = den_ff[DEN_W-1] ? DMAG_W'(-den_ff) : DMAG_W'(den_ff);
      out_in.zero = (den_ff == '0);
   end

endmodule

### sv/mrpc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, three lanes, one quotient bit per stage after an overflow check.
// Depends on mrpc_pkg.
module mrpc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mrpc_pkg::div_in_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mrpc_pkg::div_out_type out_data
);
   import mrpc_pkg::*;

   logic [QW:0]   v_ff;
   logic [QW+1:0] adv;
   div_stage_type st_ff [QW+1];
   div_stage_type st_in [QW+1];

   always_comb begin
      adv[QW+1] = out_ready;
      for (int k = QW; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end
   assign in_ready  = adv[0];
   assign out_valid = v_ff[QW];

   always_comb begin
      logic [CMP_W-1:0] dsh;
      // entry: quotient must stay below 2^QW, else flag overflow
      st_in[0].dmag = in_data.dmag;
      st_in[0].zero = in_data.zero;
      st_in[0].neg  = in_data.neg;
      st_in[0].q    = '0;
      for (int l = 0; l < 3; l++) begin
         st_in[0].rem[l] = REM_W'(in_data.nmag[l]) << FRAC_BITS;
         st_in[0].ovf[l] = CMP_W'(st_in[0].rem[l]) >= (CMP_W'(in_data.dmag) << QW);
      end
      for (int k = 1; k <= QW; k++) begin
         st_in[k] = st_ff[k-1];
         dsh = (CMP_W'(st_ff[k-1].dmag) << QW) >> k;
         for (int l = 0; l < 3; l++) begin
            if (CMP_W'(st_ff[k-1].rem[l]) >= dsh) begin
               st_in[k].rem[l]        = st_ff[k-1].rem[l] - REM_W'(dsh);
               st_in[k].q[l][QW - k] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k <= QW; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QW; k++) begin
         if (adv[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_data.q    = st_ff[QW].q;
   assign out_data.ovf  = st_ff[QW].ovf;
   assign out_data.neg  = st_ff[QW].neg;
   assign out_data.zero = st_ff[QW].zero;

endmodule

### sv/mrp_compose_top.sv
`timescale 1ns / 1ps
// MRP composition: request to result passes 5 front stages, 17 divider stages
// and 1 output register. Throughput one request per cycle while rsp_tready is high;
// the divider's one-bit-per-stage pipeline sets the depth. Stalls hold occupied stages.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
// Depends on mrpc_pkg, mrpc_front, mrpc_div.
module mrp_compose_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z (16 b each)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // f_x, f_y, f_z (16 b each), status (2 b), zero pad
);
   import mrpc_pkg::*;

   vec_pair_type req_pair;
   logic         fr_valid, fr_ready;
   div_in_type   fr_data;
   logic         dv_valid, dv_ready;
   div_out_type  dv_data;

   logic                 rsp_valid_ff;
   logic [2:0][DW-1:0]   f_ff, f_in;
   status_type           st_ff, st_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         req_pair.a[i] = req_tdata[i*DW +: DW];
         req_pair.b[i] = req_tdata[(i+3)*DW +: DW];
      end
   end

   mrpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_pair),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_data  (fr_data)
   );

   mrpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_data),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_data  (dv_data)
   );

   assign dv_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      logic sat;
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (dv_data.neg[i]) begin
            if (dv_data.ovf[i] || dv_data.q[i] > NEG_MAX) begin
               f_in[i] = NEG_MAX;
               sat     = 1'b1;
            end else begin
               f_in[i] = -dv_data.q[i];
            end
         end else begin
            if (dv_data.ovf[i] || dv_data.q[i] > POS_MAX) begin
               f_in[i] = POS_MAX;
               sat     = 1'b1;
            end else begin
               f_in[i] = dv_data.q[i];
            end
         end
      end
      if (dv_data.zero) begin
         f_in  = '0;
         st_in = ST_ZERO;
      end else begin
         st_in = sat ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dv_ready) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (dv_ready) begin
         f_ff  <= f_in;
         st_ff <= st_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, st_ff, f_ff[2], f_ff[1], f_ff[0]};

endmodule

### tb/mrp_compose_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for mrp_compose_top: random and corner-case vector pairs,
// a bit-exact predictor of the composition, random stalls on both streams.
// Depends on mrpc_pkg and the mrp_compose_top RTL.
module mrp_compose_top_test;
   import mrpc_pkg::*;

   typedef struct {
      logic [15:0] fx, fy, fz;
      status_type  st;
   } composed_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;

   composed_type expected_q[$];
   int          error_count = 0;
   int          sent_count = 0;
   int          got_count = 0;
   int          sat_count = 0;
   int          zero_count = 0;
   bit          idle_sender = 1;
   bit          idle_receiver = 1;
   int          hold_off = 0;

   mrp_compose_top dut (.*);

   always #4 clock = ~clock;

   // magnitude of num * 2^F / den, truncated, with early overflow
   function automatic longint unsigned quot_mag(longint unsigned num, longint unsigned den,
                                                output bit over);
      longint unsigned q, r;
      q = num / den;
      r = num % den;
      over = 0;
      if (q > 32768) begin
         over = 1;
         return q;
      end
      for (int i = 0; i < FRAC_BITS; i++) begin
         q = q << 1;
         r = r << 1;
         if (r >= den) begin
            r -= den;
            q |= 1;
         end
         if (q > 32768) begin
            over = 1;
            return q;
         end
      end
      return q;
   endfunction

   function automatic composed_type compose(logic [95:0] d);
      longint a[3], b[3], cr[3], num, dot, ca, cb, den, val;
      longint unsigned mag_a, mag_b, dmag, nmag, q;
      logic [15:0] f[3];
      bit over, neg, sat;
      composed_type res;
      mag_a = 0;
      mag_b = 0;
      dot = 0;
      sat = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = longint'($signed(d[16*i +: 16]));
         b[i] = longint'($signed(d[48 + 16*i +: 16]));
         mag_a += a[i] * a[i];
         mag_b += b[i] * b[i];
         dot += a[i] * b[i];
      end
      cr[0] = b[1] * a[2] - b[2] * a[1];
      cr[1] = b[2] * a[0] - b[0] * a[2];
      cr[2] = b[0] * a[1] - b[1] * a[0];
      ca = (64'sd1 <<< FRAC_BITS) - longint'(mag_a >> FRAC_BITS);
      cb = (64'sd1 <<< FRAC_BITS) - longint'(mag_b >> FRAC_BITS);
      den = (64'sd1 <<< (2 * FRAC_BITS)) + longint'((mag_a * mag_b) >> (2 * FRAC_BITS))
            - 2 * dot;
      if (den == 0) begin
         res.fx = 0;
         res.fy = 0;
         res.fz = 0;
         res.st = ST_ZERO;
         return res;
      end
      dmag = den < 0 ? -den : den;
      for (int i = 0; i < 3; i++) begin
         num = ca * b[i] + cb * a[i] - 2 * cr[i];
         nmag = num < 0 ? -num : num;
         neg = (num < 0) != (den < 0);
         q = quot_mag(nmag, dmag, over);
         if (neg) begin
            if (over || q > 32768) begin
               val = -32768;
               sat = 1;
            end else val = -longint'(q);
         end else begin
            if (over || q > 32767) begin
               val = 32767;
               sat = 1;
            end else val = longint'(q);
         end
         f[i] = val[15:0];
      end
      res.fx = f[0];
      res.fy = f[1];
      res.fz = f[2];
      res.st = sat ? ST_SAT : ST_OK;
      return res;
   endfunction

   // called at a falling edge; returns at a falling edge with tvalid still up,
   // so the next request can follow without a gap
   task automatic send_pair(logic [15:0] ax, ay, az, bx, by, bz);
      while (idle_sender && $urandom_range(99) < 36) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tdata <= {bz, by, bx, az, ay, ax};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(compose({bz, by, bx, az, ay, ax}));
      sent_count++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(8192)) - 4096);
         3: return 16'($signed($urandom_range(32768)) - 16384);
         default: return 16'($urandom);
      endcase
   endfunction

   // receiver: random stalls, or a counted hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_tready <= 0;
         hold_off <= hold_off - 1;
      end else rsp_tready <= !(idle_receiver && $urandom_range(99) < 36);
   end

   always @(posedge clock) begin
      composed_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_count++;
         if (expected_q.size() == 0) begin
            $error("result with nothing expected: %h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata[15:0] !== want.fx) begin
               $error("f_x expected %h got %h", want.fx, rsp_tdata[15:0]);
               error_count++;
            end
            if (rsp_tdata[31:16] !== want.fy) begin
               $error("f_y expected %h got %h", want.fy, rsp_tdata[31:16]);
               error_count++;
            end
            if (rsp_tdata[47:32] !== want.fz) begin
               $error("f_z expected %h got %h", want.fz, rsp_tdata[47:32]);
               error_count++;
            end
            if (rsp_tdata[49:48] !== want.st) begin
               $error("status expected %0d got %0d", want.st, rsp_tdata[49:48]);
               error_count++;
            end
            if (want.st == ST_SAT) sat_count++;
            if (want.st == ST_ZERO) zero_count++;
         end
      end
   end

   task automatic test_directed();
      send_pair(0, 0, 0, 0, 0, 0);
      send_pair(16'h4000, 0, 0, 0, 16'h4000, 0);
      send_pair(16'h4000, 0, 0, 16'h4000, 0, 0);            // zero denominator
      send_pair(0, 16'hc000, 0, 0, 16'hc000, 0);
      send_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_pair(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_pair(16'h8000, 0, 0, 16'h7fff, 0, 0);
      send_pair(16'h3fff, 0, 0, 16'h3fff, 0, 0);            // near singular, saturates
      send_pair(16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff);
      send_pair(16'h2000, 16'h1000, 16'hf000, 16'h0800, 16'he000, 16'h1800);
      send_pair(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
      send_pair(0, 0, 16'h4000, 0, 0, 16'h4000);
      send_pair(0, 0, 16'hc000, 0, 0, 16'hc000);
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++)
         send_pair(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                   rand_comp());
   endtask

   task automatic test_back_to_back(int n);
      idle_sender = 0;
      idle_receiver = 0;
      test_random(n);
      idle_sender = 1;
      idle_receiver = 1;
   endtask

   task automatic test_backpressure();
      hold_off <= 120;
      idle_sender = 0;
      test_random(60);
      idle_sender = 1;
   endtask

   // drop the request and wait for every outstanding result
   task automatic drain();
      req_tvalid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      drain();
      test_random(400);
      test_backpressure();
      drain();
      test_back_to_back(200);
      test_random(400);
      drain();
      repeat (40) @(posedge clock);
      $display("sent %0d pairs, checked %0d results (%0d saturated, %0d singular)",
               sent_count, got_count, sat_count, zero_count);
      $display("directed corners, random pairs, long output stall, back-to-back streaming");
      if (error_count == 0 && expected_q.size() == 0)
         $display("mrp_compose_top_test: done, clean");
      else
         $display("mrp_compose_top_test: done, errors");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("mrp_compose_top_test: done, errors");
      $finish;
   end
endmodule
